// ----- rtl/lptk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptk_pkg
// shared widths, codes and types of the last pressed key tracker
// ----------------------------------------------------------------------------
package lptk_pkg;

    localparam int KEY_SLOTS_DEFAULT = 16;
    localparam int MASK_W            = 16;
    localparam int LIST_DEPTH        = 16;
    localparam int SLOT_W            = 4;
    localparam int COUNT_W           = 5;
    localparam int POS_W             = 5;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic signed [POS_W-1:0] NO_KEY = -5'sd1;

    // register index, taken from paddr[2]
    localparam logic REG_LEFT_ENABLE  = 1'b0;
    localparam logic REG_RIGHT_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_SCAN,
        HS_PUSH
    } hand_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_DELIVER
    } top_state_t;

    typedef struct packed {
        logic                    done;
        logic signed [POS_W-1:0] position;
    } hand_result_t;

endpackage

// ----- rtl/last_pressed_key_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// last_pressed_key_tracker
// last note priority for two hands, one recency list per hand
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) takes one frame item: the sampled down
// masks of the left and right key slots. The result channel (m_valid/m_ready)
// returns one item per frame: for each hand the most recently pressed slot
// still held, or -1 when none is held. Enable masks are written over the APB
// port (left at 0x0, right at 0x4); the user writes them only while the block
// is idle, which the block itself does not enforce. Each hand walks its list
// memory once to drop released slots, one entry a cycle through a registered
// read, then visits every key slot once to push new presses. A new frame is
// accepted while the previous result still waits in the output register; a
// stalled receiver holds the block before delivery of the next result. Reset
// empties both lists, marks all keys up and clears the enable masks; the list
// memories need no clearing pass.
// ----------------------------------------------------------------------------
module last_pressed_key_tracker import lptk_pkg::*; #(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MASK_W-1:0]       s_left_keys_down,
    input  logic [MASK_W-1:0]       s_right_keys_down,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_left_position,
    output logic signed [POS_W-1:0] m_right_position
);

    top_state_t state_reg, state_next;

    logic [MASK_W-1:0] left_enable_reg;
    logic [MASK_W-1:0] right_enable_reg;
    logic              left_done_reg, left_done_next;
    logic              right_done_reg, right_done_next;
    logic              m_valid_reg, m_valid_next;
    logic signed [POS_W-1:0] m_left_reg, m_right_reg;

    hand_result_t left_res;
    hand_result_t right_res;

    logic in_take;
    logic cfg_write;
    logic both_done;
    logic out_free;
    logic out_load;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_take   = s_valid && s_ready;
    assign both_done = (left_done_reg || left_res.done) && (right_done_reg || right_res.done);
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == TS_DELIVER) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_enable_reg  <= '0;
            right_enable_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LEFT_ENABLE:  left_enable_reg  <= pwdata[MASK_W-1:0];
                REG_RIGHT_ENABLE: right_enable_reg <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_LEFT_ENABLE:  prdata = APB_DATA_W'(left_enable_reg);
            REG_RIGHT_ENABLE: prdata = APB_DATA_W'(right_enable_reg);
            default: ;
        endcase
    end

    lptk_hand #(.KEY_SLOTS(KEY_SLOTS)) u_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_take),
        .keys_down   (s_left_keys_down),
        .enable_mask (left_enable_reg),
        .result      (left_res)
    );

    lptk_hand #(.KEY_SLOTS(KEY_SLOTS)) u_right (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_take),
        .keys_down   (s_right_keys_down),
        .enable_mask (right_enable_reg),
        .result      (right_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE: begin
                if (in_take) state_next = TS_RUN;
            end
            TS_RUN: begin
                if (both_done) state_next = TS_DELIVER;
            end
            TS_DELIVER: begin
                if (out_free) state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready         = (state_reg == TS_IDLE);
        left_done_next  = left_done_reg;
        right_done_next = right_done_reg;
        m_valid_next    = m_valid_reg;
        if (in_take) begin
            left_done_next  = 1'b0;
            right_done_next = 1'b0;
        end else begin
            if (left_res.done)  left_done_next  = 1'b1;
            if (right_res.done) right_done_next = 1'b1;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= TS_IDLE;
            left_done_reg  <= 1'b0;
            right_done_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            left_done_reg  <= left_done_next;
            right_done_reg <= right_done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_left_reg  <= left_res.position;
            m_right_reg <= right_res.position;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_position  = m_left_reg;
    assign m_right_position = m_right_reg;

    // hands only finish while a frame is in flight
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_res.done || right_res.done) |-> (state_reg == TS_RUN))
        else $error("hand finished outside a frame");

    // a result is in range: -1 or a slot index
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_left_position[POS_W-1] || m_left_position == NO_KEY) &&
                     (!m_right_position[POS_W-1] || m_right_position == NO_KEY)))
        else $error("position out of range");

    // an accepted frame starts both hands
    a_take_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> (state_reg == TS_RUN) && !left_done_reg && !right_done_reg)
        else $error("frame not started");

    // a delivery fills the output register
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result lost at delivery");

endmodule

// ----- rtl/lptk_hand.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptk_hand
// one hand: recency list in a circular memory, compacted then pushed per frame
// ----------------------------------------------------------------------------
module lptk_hand import lptk_pkg::*; #(
    parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MASK_W-1:0]  keys_down,
    input  logic [MASK_W-1:0]  enable_mask,
    output hand_result_t       result
);

    localparam int SLOTS_EFF = (KEY_SLOTS > MASK_W) ? MASK_W : KEY_SLOTS;
    localparam logic [MASK_W-1:0] VALID_MASK =
        (SLOTS_EFF >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << SLOTS_EFF) - 64'd1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS_EFF - 1);
    localparam logic [COUNT_W-1:0] LIST_MAX  = COUNT_W'(SLOTS_EFF);

    hand_state_t state_reg, state_next;

    logic [MASK_W-1:0]      now_reg, now_next;
    logic [MASK_W-1:0]      prev_mask_reg, prev_mask_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]      head_reg, head_next;
    logic [COUNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [COUNT_W-1:0]     keep_cnt_reg, keep_cnt_next;
    logic [SLOT_W-1:0]      push_idx_reg, push_idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]      front_reg, front_next;
    logic                   done_reg, done_next;
    logic signed [POS_W-1:0] position_reg, position_next;

    logic [SLOT_W-1:0] mem [LIST_DEPTH];
    logic [SLOT_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;

    logic [MASK_W-1:0]  released;
    logic [MASK_W-1:0]  pressed;
    logic               rd_issue;
    logic               scan_end;
    logic               keep;
    logic               push_now;
    logic               push_last;
    logic [COUNT_W-1:0] k_push;
    logic [SLOT_W-1:0]  front_value;

    assign released  = prev_mask_reg & ~now_reg;
    assign pressed   = now_reg & ~prev_mask_reg;
    assign rd_issue  = (state_reg == HS_SCAN) && (scan_idx_reg < count_reg);
    assign scan_end  = (state_reg == HS_SCAN) && (scan_idx_reg == count_reg) && !rd_pend_reg;
    assign keep      = (state_reg == HS_SCAN) && rd_pend_reg && !released[rd_data_reg];
    assign push_now  = (state_reg == HS_PUSH) && pressed[push_idx_reg]
                       && (keep_cnt_reg < LIST_MAX);
    assign push_last = (state_reg == HS_PUSH) && (push_idx_reg == LAST_SLOT);
    assign k_push    = keep_cnt_reg + COUNT_W'(push_now);
    assign front_value = push_now ? push_idx_reg : front_reg;

    // logical entry j lives at head + j
    assign rd_addr = head_reg + scan_idx_reg[SLOT_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = head_reg + keep_cnt_reg[SLOT_W-1:0];
        wr_data = rd_data_reg;
        if (keep) begin
            wr_en = 1'b1;
        end else if (push_now) begin
            wr_en   = 1'b1;
            wr_addr = head_reg - SLOT_W'(1);
            wr_data = push_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            HS_IDLE: begin
                if (start) state_next = HS_SCAN;
            end
            HS_SCAN: begin
                if (scan_end) state_next = HS_PUSH;
            end
            HS_PUSH: begin
                if (push_last) state_next = HS_IDLE;
            end
            default: state_next = HS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        now_next       = now_reg;
        prev_mask_next = prev_mask_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        scan_idx_next  = scan_idx_reg;
        keep_cnt_next  = keep_cnt_reg;
        push_idx_next  = push_idx_reg;
        rd_pend_next   = rd_pend_reg;
        front_next     = front_reg;
        done_next      = 1'b0;
        position_next  = position_reg;
        unique case (state_reg)
            HS_IDLE: begin
                if (start) begin
                    now_next      = keys_down & enable_mask & VALID_MASK;
                    scan_idx_next = '0;
                    keep_cnt_next = '0;
                    rd_pend_next  = 1'b0;
                end
            end
            HS_SCAN: begin
                rd_pend_next = rd_issue;
                if (rd_issue) scan_idx_next = scan_idx_reg + COUNT_W'(1);
                if (keep) begin
                    keep_cnt_next = keep_cnt_reg + COUNT_W'(1);
                    // first survivor is the front unless something is pushed
                    if (keep_cnt_reg == '0) front_next = rd_data_reg;
                end
                if (scan_end) push_idx_next = '0;
            end
            HS_PUSH: begin
                if (push_now) begin
                    head_next     = head_reg - SLOT_W'(1);
                    front_next    = push_idx_reg;
                    keep_cnt_next = k_push;
                end
                if (push_last) begin
                    count_next     = k_push;
                    prev_mask_next = now_reg;
                    done_next      = 1'b1;
                    position_next  = (k_push == '0) ? NO_KEY
                                                    : $signed({1'b0, front_value});
                end else begin
                    push_idx_next = push_idx_reg + SLOT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= HS_IDLE;
            prev_mask_reg <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_mask_reg <= prev_mask_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rd_pend_reg   <= rd_pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        scan_idx_reg <= scan_idx_next;
        keep_cnt_reg <= keep_cnt_next;
        push_idx_reg <= push_idx_next;
        front_reg    <= front_next;
        position_reg <= position_next;
    end

    assign result.done     = done_reg;
    assign result.position = position_reg;

endmodule

// ----- tb/lptk_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lptk_checker
// watches the key tracker's channels and checks every result item
// ----------------------------------------------------------------------------
// Follows enable mask writes on the APB port and every accepted frame item.
// It keeps its own recency list per hand and queues the expected left and
// right positions. Each result item is compared against the oldest expected
// one. fail_count and pending go to the testbench top.
// ----------------------------------------------------------------------------
module lptk_checker import lptk_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    pready,

    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [MASK_W-1:0]       s_left_keys_down,
    input  logic [MASK_W-1:0]       s_right_keys_down,

    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [POS_W-1:0] m_left_position,
    input  logic signed [POS_W-1:0] m_right_position,

    output int                      fail_count,
    output int                      pending
);

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        logic signed [POS_W-1:0] left_pos;
        logic signed [POS_W-1:0] right_pos;
    } hand_positions_t;

    // per hand: held slots, most recent first
    logic [SLOT_W-1:0] recency_list [2][LIST_DEPTH];
    int                held_count   [2];
    logic [MASK_W-1:0] last_down    [2];
    logic [MASK_W-1:0] enable_mask  [2];

    hand_positions_t   positions_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic track_hand(input int h, input logic [MASK_W-1:0] raw,
                              output logic signed [POS_W-1:0] front);
        logic [MASK_W-1:0] now_down;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] pressed;
        int kept;
        now_down = raw & enable_mask[h];
        released = last_down[h] & ~now_down;
        pressed  = now_down & ~last_down[h];

        kept = 0;
        for (int j = 0; j < held_count[h]; j++) begin
            if (!released[recency_list[h][j]]) begin
                recency_list[h][kept] = recency_list[h][j];
                kept++;
            end
        end
        held_count[h] = kept;

        // ascending order, so the highest new slot lands in front
        for (int i = 0; i < KEY_SLOTS_DEFAULT; i++) begin
            if (pressed[i] && held_count[h] < KEY_SLOTS_DEFAULT) begin
                for (int j = held_count[h]; j > 0; j--)
                    recency_list[h][j] = recency_list[h][j-1];
                recency_list[h][0] = SLOT_W'(i);
                held_count[h]++;
            end
        end

        last_down[h] = now_down;
        if (held_count[h] == 0)
            front = NO_KEY;
        else
            front = $signed({1'b0, recency_list[h][0]});
    endtask

    always @(posedge aclk) begin
        hand_positions_t want;
        hand_positions_t got;
        if (!aresetn) begin
            for (int h = 0; h < 2; h++) begin
                held_count[h]  = 0;
                last_down[h]   = '0;
                enable_mask[h] = '0;
            end
            positions_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_LEFT_ENABLE)
                    enable_mask[LEFT] = pwdata[MASK_W-1:0];
                else
                    enable_mask[RIGHT] = pwdata[MASK_W-1:0];
            end

            // pop before push: a result can never stem from this edge's item
            if (m_valid && m_ready) begin
                got.left_pos  = m_left_position;
                got.right_pos = m_right_position;
                if (positions_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result item, left %0d right %0d",
                             $time, got.left_pos, got.right_pos);
                end else begin
                    want = positions_q.pop_front();
                    if (got.left_pos !== want.left_pos) begin
                        fail_count++;
                        $display("%0t: left_position expected %0d, got %0d",
                                 $time, want.left_pos, got.left_pos);
                    end
                    if (got.right_pos !== want.right_pos) begin
                        fail_count++;
                        $display("%0t: right_position expected %0d, got %0d",
                                 $time, want.right_pos, got.right_pos);
                    end
                end
            end

            if (s_valid && s_ready) begin
                track_hand(LEFT, s_left_keys_down, want.left_pos);
                track_hand(RIGHT, s_right_keys_down, want.right_pos);
                positions_q.push_back(want);
            end

            pending <= positions_q.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the last pressed key tracker
// ----------------------------------------------------------------------------
// Writes the enable masks over APB while the block is idle and sends frame
// items: a directed part first, then phases of random press and release
// sequences under changing idle and stall patterns, including a long receiver
// hold-off. Checking is done by lptk_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import lptk_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 125;
    localparam int PRESS_ITEMS  = 25;
    localparam int TAIL_CYCLES  = 60;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;

    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [MASK_W-1:0]       s_left_keys_down  = '0;
    logic [MASK_W-1:0]       s_right_keys_down = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [POS_W-1:0] m_left_position;
    logic signed [POS_W-1:0] m_right_position;

    int fail_count;
    int pending;

    int src_idle   = 0;
    int sink_stall = 0;
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    logic [MASK_W-1:0] left_keys  = '0;
    logic [MASK_W-1:0] right_keys = '0;

    always #HALF_PERIOD aclk = ~aclk;

    last_pressed_key_tracker u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_left_keys_down  (s_left_keys_down),
        .s_right_keys_down (s_right_keys_down),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_position   (m_left_position),
        .m_right_position  (m_right_position)
    );

    lptk_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_left_keys_down  (s_left_keys_down),
        .s_right_keys_down (s_right_keys_down),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_position   (m_left_position),
        .m_right_position  (m_right_position),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_frame(input logic [MASK_W-1:0] left_down,
                              input logic [MASK_W-1:0] right_down);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_left_keys_down  <= left_down;
        s_right_keys_down <= right_down;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // sender stays quiet until every expected result item is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_enable(input logic idx, input logic [MASK_W-1:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(mask);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_enables(input logic [MASK_W-1:0] left_en,
                               input logic [MASK_W-1:0] right_en);
        write_enable(REG_LEFT_ENABLE, left_en);
        write_enable(REG_RIGHT_ENABLE, right_en);
    endtask

    // mostly a few keys going up or down, sometimes a jump
    function automatic logic [MASK_W-1:0] next_keys(input logic [MASK_W-1:0] cur);
        logic [MASK_W-1:0] keys;
        int pick;
        keys = cur;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            repeat ($urandom_range(1, 3))
                keys[$urandom_range(0, MASK_W-1)] ^= 1'b1;
        end else if (pick < 85) begin
            keys = MASK_W'($urandom_range(0, 65535));
        end else if (pick < 90) begin
            keys = '0;
        end else if (pick < 95) begin
            keys = '1;
        end
        return keys;
    endfunction

    task automatic random_frames(input int count);
        repeat (count) begin
            left_keys  = next_keys(left_keys);
            right_keys = next_keys(right_keys);
            send_frame(left_keys, right_keys);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // enables still cleared: nothing is held
        send_frame(16'hFFFF, 16'hFFFF);
        drain();
        set_enables(16'hFFFF, 16'hFFFF);

        send_frame(16'h0000, 16'h0000);
        send_frame(16'h0001, 16'h8000);
        send_frame(16'h8001, 16'h8001);
        send_frame(16'h8000, 16'h0001);
        send_frame(16'hFFFF, 16'hFFFF);
        send_frame(16'h7FFF, 16'hFFFE);
        send_frame(16'h0000, 16'h0000);
        // one press per frame, then release the newest ones
        send_frame(16'h0008, 16'h0004);
        send_frame(16'h0088, 16'h0044);
        send_frame(16'h008C, 16'h0046);
        send_frame(16'h0088, 16'h0044);
        send_frame(16'h0008, 16'h0004);
        send_frame(16'hA5A5, 16'h5A5A);
        send_frame(16'h5A5A, 16'hA5A5);
        send_frame(16'hFFFF, 16'hFFFF);
        drain();
        // held keys that get disabled count as released
        set_enables(16'h00FF, 16'hFF00);
        send_frame(16'hFFFF, 16'hFFFF);
        drain();
        // keys enabled while down count as new presses
        set_enables(16'hFFFF, 16'hFFFF);
        send_frame(16'hFFFF, 16'hFFFF);
        send_frame(16'hFFFF, 16'h0000);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    set_enables(16'hFFFF, 16'hFFFF);
                    src_idle = 0;  sink_stall = 0;
                end
                1: begin
                    set_enables(16'h0000, 16'hFFFF);
                    src_idle = 84; sink_stall = 0;
                end
                2: begin
                    set_enables(MASK_W'($urandom_range(0, 65535)),
                                MASK_W'($urandom_range(0, 65535)));
                    src_idle = 0;  sink_stall = 84;
                end
                3: begin
                    set_enables(16'hFFFF, 16'h0000);
                    src_idle = 33; sink_stall = 33;
                end
                default: begin
                    set_enables(MASK_W'($urandom_range(0, 65535)), 16'hFFFF);
                    src_idle = 0;  sink_stall = 0;
                end
            endcase
            random_frames(PHASE_ITEMS);
            drain();

            if (ph == 2) begin
                // receiver holds off while frames keep coming
                src_idle   = 0;
                sink_stall = 0;
                hold_asks  = hold_asks + 1;
                random_frames(PRESS_ITEMS);
                drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- last_pressed_key_tracker.f -----
rtl/lptk_pkg.sv
rtl/lptk_hand.sv
rtl/last_pressed_key_tracker.sv
tb/lptk_checker.sv
tb/testbench.sv
